// ----- hw/rtl/dmaexp_pkg.sv -----
package dmaexp_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_READ  = 3'd2,
    OP_FF00  = 3'd3,
    OP_DONE  = 3'd4
  } op_e;

  // register offsets on the host bus
  localparam logic [4:0] REG_STATUS    = 5'd0;
  localparam logic [4:0] REG_COMMAND   = 5'd1;
  localparam logic [4:0] REG_HOST_LO   = 5'd2;
  localparam logic [4:0] REG_HOST_HI   = 5'd3;
  localparam logic [4:0] REG_EXP_LO    = 5'd4;
  localparam logic [4:0] REG_EXP_HI    = 5'd5;
  localparam logic [4:0] REG_BANK      = 5'd6;
  localparam logic [4:0] REG_LEN_LO    = 5'd7;
  localparam logic [4:0] REG_LEN_HI    = 5'd8;
  localparam logic [4:0] REG_IRQ_MASK  = 5'd9;
  localparam logic [4:0] REG_ADDR_CTRL = 5'd10;

  // configuration register indexes
  localparam logic [1:0] CFG_CHIPS     = 2'd0;
  localparam logic [1:0] CFG_BANK_MASK = 2'd1;
  localparam logic [1:0] CFG_ADDR_MASK = 2'd2;

  // bit positions
  localparam int unsigned ST_IRQ    = 7;
  localparam int unsigned ST_EOB    = 6;
  localparam int unsigned ST_VERR   = 5;
  localparam int unsigned ST_CHIPS  = 4;
  localparam int unsigned CMD_EXEC  = 7;
  localparam int unsigned CMD_AUTO  = 5;
  localparam int unsigned CMD_NOFF  = 4;
  localparam int unsigned IM_ENABLE = 7;
  localparam int unsigned IM_EOB    = 6;
  localparam int unsigned IM_VERR   = 5;
  localparam int unsigned AC_FIXH   = 7;
  localparam int unsigned AC_FIXR   = 6;

  localparam logic [7:0]  IM_UNUSED     = 8'h1f;
  localparam logic [7:0]  AC_UNUSED     = 8'h3f;
  localparam logic [7:0]  CMD_RESET     = 8'h10;
  localparam logic [7:0]  STATUS_RESET  = 8'h10;
  localparam logic [7:0]  BANK_MASK_RST = 8'hf8;
  localparam logic [23:0] ADDR_MASK_RST = 24'h07ffff;
  localparam logic [15:0] LEN_RESET     = 16'hffff;
  localparam logic [7:0]  UNUSED_READ   = 8'hff;

  typedef logic [10:0] ticks_t;
  localparam ticks_t TICKS_MAX = 11'h7ff;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        start_transfer;
    logic        irq_drive;
    logic [7:0]  cur_command;
    logic [15:0] cur_host_addr;
    logic [23:0] cur_reu_addr;
    logic [15:0] cur_length;
    logic [7:0]  cur_addr_control;
  } res_t;

endpackage

// ----- hw/rtl/dma_expander_register_file.sv -----
// A result word is registered in the result register, or in the skid if output stalls.
// Throughput: one input word per cycle unless stalled; all register updates for a
// word settle in the single combinational stage between input port and result register.
// A two-entry output (result register plus skid) keeps the input open for one stall.
// rst_ni sets all but the result/skid data to power-up values, the config to defaults.
module dma_expander_register_file #(
  parameter int unsigned RESET_HOLD_TICKS = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [4:0]  reg_offset_i,
  input  logic [7:0]  write_data_i,
  input  logic        cpu_reset_low_i,
  input  logic        irq_line_low_i,
  input  logic [15:0] done_host_addr_i,
  input  logic [23:0] done_reu_addr_i,
  input  logic [15:0] done_length_i,
  input  logic        done_end_of_block_i,
  input  logic        done_verify_error_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        start_transfer_o,
  output logic        irq_drive_o,
  output logic [7:0]  cur_command_o,
  output logic [15:0] cur_host_addr_o,
  output logic [23:0] cur_reu_addr_o,
  output logic [15:0] cur_length_o,
  output logic [7:0]  cur_addr_control_o
);

  localparam dmaexp_pkg::ticks_t HoldTicks = dmaexp_pkg::ticks_t'(RESET_HOLD_TICKS);

  logic        chips_q, chips_d;
  logic [7:0]  bank_mask_q, bank_mask_d;
  logic [23:0] addr_mask_q, addr_mask_d;

  logic [7:0]  status_q, status_d;
  logic [7:0]  command_q, command_d;
  logic [15:0] host_q, host_d, host_sh_q, host_sh_d;
  logic [15:0] exp_q, exp_d, exp_sh_q, exp_sh_d;
  logic [7:0]  bank_q, bank_d, bank_sh_q, bank_sh_d;
  logic [15:0] len_q, len_d, len_sh_q, len_sh_d;
  logic [7:0]  irq_mask_q, irq_mask_d;
  logic [7:0]  ac_q, ac_d;
  logic        wait_ff00_q, wait_ff00_d;
  logic        irq_pend_q, irq_pend_d;
  logic        irq_asserted_q, irq_asserted_d;
  dmaexp_pkg::ticks_t ticks_q, ticks_d;

  dmaexp_pkg::res_t res_d, out_q, out_d, skid_q, skid_d;
  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic        accept, pop;
  logic [23:0] reu_masked;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign pop        = out_valid_q & ~out_stall_i;
  assign reu_masked = done_reu_addr_i & addr_mask_q;

  // configuration writes
  always_comb begin
    chips_d     = chips_q;
    bank_mask_d = bank_mask_q;
    addr_mask_d = addr_mask_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        dmaexp_pkg::CFG_CHIPS:     chips_d     = cfg_data_i[0];
        dmaexp_pkg::CFG_BANK_MASK: bank_mask_d = cfg_data_i[7:0];
        dmaexp_pkg::CFG_ADDR_MASK: addr_mask_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // register file update for one bus word
  always_comb begin
    status_d       = status_q;
    command_d      = command_q;
    host_d         = host_q;
    host_sh_d      = host_sh_q;
    exp_d          = exp_q;
    exp_sh_d       = exp_sh_q;
    bank_d         = bank_q;
    bank_sh_d      = bank_sh_q;
    len_d          = len_q;
    len_sh_d       = len_sh_q;
    irq_mask_d     = irq_mask_q;
    ac_d           = ac_q;
    wait_ff00_d    = wait_ff00_q;
    irq_pend_d     = irq_pend_q;
    irq_asserted_d = irq_asserted_q;
    ticks_d        = ticks_q;
    res_d          = '0;

    if (accept) begin
      // long host reset: reset registers before the access
      if (cpu_reset_low_i) begin
        if (ticks_q != dmaexp_pkg::TICKS_MAX) begin
          ticks_d = ticks_q + 11'd1;
        end
        if (ticks_d > HoldTicks) begin
          irq_asserted_d = 1'b0;
          irq_pend_d     = 1'b0;
          wait_ff00_d    = 1'b0;
          status_d[dmaexp_pkg::ST_CHIPS] = chips_q;
          command_d      = dmaexp_pkg::CMD_RESET;
          len_d          = dmaexp_pkg::LEN_RESET;
          len_sh_d       = dmaexp_pkg::LEN_RESET;
          host_d         = '0;
          exp_d          = '0;
          exp_sh_d       = '0;
          bank_d         = bank_mask_q;
          bank_sh_d      = bank_mask_q;
          irq_mask_d     = dmaexp_pkg::IM_UNUSED;
          ac_d           = dmaexp_pkg::AC_UNUSED;
        end
      end else begin
        ticks_d = '0;
      end

      case (dmaexp_pkg::op_e'(op_i))
        dmaexp_pkg::OP_WRITE: begin
          unique case (reg_offset_i)
            dmaexp_pkg::REG_COMMAND: begin
              command_d = write_data_i;
              if (write_data_i[dmaexp_pkg::CMD_EXEC] && write_data_i[dmaexp_pkg::CMD_NOFF]) begin
                res_d.start_transfer = 1'b1;
                wait_ff00_d          = 1'b0;
              end else if (write_data_i[dmaexp_pkg::CMD_EXEC]) begin
                wait_ff00_d = 1'b1;
              end
            end
            dmaexp_pkg::REG_HOST_LO: begin
              host_sh_d = {host_sh_d[15:8], write_data_i};
              host_d    = host_sh_d;
            end
            dmaexp_pkg::REG_HOST_HI: begin
              host_sh_d = {write_data_i, host_sh_d[7:0]};
              host_d    = host_sh_d;
            end
            dmaexp_pkg::REG_EXP_LO: begin
              exp_sh_d = {exp_sh_d[15:8], write_data_i};
              exp_d    = exp_sh_d;
            end
            dmaexp_pkg::REG_EXP_HI: begin
              exp_sh_d = {write_data_i, exp_sh_d[7:0]};
              exp_d    = exp_sh_d;
            end
            dmaexp_pkg::REG_BANK: begin
              bank_sh_d = write_data_i & ~bank_mask_q;
              bank_d    = bank_sh_d;
            end
            dmaexp_pkg::REG_LEN_LO: begin
              len_sh_d = {len_sh_d[15:8], write_data_i};
              len_d    = len_sh_d;
            end
            dmaexp_pkg::REG_LEN_HI: begin
              len_sh_d = {write_data_i, len_sh_d[7:0]};
              len_d    = len_sh_d;
            end
            dmaexp_pkg::REG_IRQ_MASK: begin
              irq_mask_d = write_data_i | dmaexp_pkg::IM_UNUSED;
              if (status_d[dmaexp_pkg::ST_EOB] && irq_mask_d[dmaexp_pkg::IM_EOB] &&
                  irq_mask_d[dmaexp_pkg::IM_ENABLE]) begin
                status_d[dmaexp_pkg::ST_IRQ] = 1'b1;
                irq_pend_d = 1'b1;
              end
              if (status_d[dmaexp_pkg::ST_VERR] && irq_mask_d[dmaexp_pkg::IM_VERR] &&
                  irq_mask_d[dmaexp_pkg::IM_ENABLE]) begin
                status_d[dmaexp_pkg::ST_IRQ] = 1'b1;
                irq_pend_d = 1'b1;
              end
            end
            dmaexp_pkg::REG_ADDR_CTRL: ac_d = write_data_i | dmaexp_pkg::AC_UNUSED;
            default: ;
          endcase
        end
        dmaexp_pkg::OP_READ: begin
          unique case (reg_offset_i)
            dmaexp_pkg::REG_STATUS: begin
              res_d.read_data = status_d;
              status_d[dmaexp_pkg::ST_IRQ]  = 1'b0;
              status_d[dmaexp_pkg::ST_EOB]  = 1'b0;
              status_d[dmaexp_pkg::ST_VERR] = 1'b0;
              irq_asserted_d = 1'b0;
            end
            dmaexp_pkg::REG_COMMAND:   res_d.read_data = command_d;
            dmaexp_pkg::REG_HOST_LO:   res_d.read_data = host_d[7:0];
            dmaexp_pkg::REG_HOST_HI:   res_d.read_data = host_d[15:8];
            dmaexp_pkg::REG_EXP_LO:    res_d.read_data = exp_d[7:0];
            dmaexp_pkg::REG_EXP_HI:    res_d.read_data = exp_d[15:8];
            dmaexp_pkg::REG_BANK:      res_d.read_data = bank_d | bank_mask_q;
            dmaexp_pkg::REG_LEN_LO:    res_d.read_data = len_d[7:0];
            dmaexp_pkg::REG_LEN_HI:    res_d.read_data = len_d[15:8];
            dmaexp_pkg::REG_IRQ_MASK:  res_d.read_data = irq_mask_d;
            dmaexp_pkg::REG_ADDR_CTRL: res_d.read_data = ac_d;
            default:                   res_d.read_data = dmaexp_pkg::UNUSED_READ;
          endcase
        end
        dmaexp_pkg::OP_FF00: begin
          if (wait_ff00_d) begin
            res_d.start_transfer = 1'b1;
            wait_ff00_d          = 1'b0;
          end
        end
        dmaexp_pkg::OP_DONE: begin
          status_d[dmaexp_pkg::ST_EOB]  = status_d[dmaexp_pkg::ST_EOB]  | done_end_of_block_i;
          status_d[dmaexp_pkg::ST_VERR] = status_d[dmaexp_pkg::ST_VERR] | done_verify_error_i;
          if (!command_d[dmaexp_pkg::CMD_AUTO]) begin
            if (!ac_d[dmaexp_pkg::AC_FIXH]) begin
              host_d = done_host_addr_i;
            end
            if (!ac_d[dmaexp_pkg::AC_FIXR]) begin
              exp_d  = reu_masked[15:0];
              bank_d = reu_masked[23:16];
            end
            len_d = done_length_i;
          end else begin
            // autoload: reload from shadows
            host_d = host_sh_d;
            exp_d  = exp_sh_d;
            bank_d = bank_sh_d;
            len_d  = len_sh_d;
          end
          if ((done_end_of_block_i && irq_mask_d[dmaexp_pkg::IM_EOB] &&
               irq_mask_d[dmaexp_pkg::IM_ENABLE]) ||
              (done_verify_error_i && irq_mask_d[dmaexp_pkg::IM_VERR] &&
               irq_mask_d[dmaexp_pkg::IM_ENABLE])) begin
            status_d[dmaexp_pkg::ST_IRQ] = 1'b1;
            irq_pend_d = 1'b1;
          end
        end
        default: ;
      endcase

      // take the line once nobody else holds it low
      if (irq_pend_d && !irq_line_low_i) begin
        irq_pend_d     = 1'b0;
        irq_asserted_d = 1'b1;
      end
    end

    res_d.irq_drive        = irq_asserted_d;
    res_d.cur_command      = command_d;
    res_d.cur_host_addr    = host_d;
    res_d.cur_reu_addr     = {bank_d, exp_d};
    res_d.cur_length       = len_d;
    res_d.cur_addr_control = ac_d;
  end

  // result register with skid stage
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_d;
        out_valid_d = accept;
      end
    end else if (accept) begin
      skid_d       = res_d;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chips_q        <= 1'b1;
      bank_mask_q    <= dmaexp_pkg::BANK_MASK_RST;
      addr_mask_q    <= dmaexp_pkg::ADDR_MASK_RST;
      status_q       <= dmaexp_pkg::STATUS_RESET;
      command_q      <= dmaexp_pkg::CMD_RESET;
      host_q         <= '0;
      host_sh_q      <= '0;
      exp_q          <= '0;
      exp_sh_q       <= '0;
      bank_q         <= dmaexp_pkg::BANK_MASK_RST;
      bank_sh_q      <= dmaexp_pkg::BANK_MASK_RST;
      len_q          <= dmaexp_pkg::LEN_RESET;
      len_sh_q       <= dmaexp_pkg::LEN_RESET;
      irq_mask_q     <= dmaexp_pkg::IM_UNUSED;
      ac_q           <= dmaexp_pkg::AC_UNUSED;
      wait_ff00_q    <= 1'b0;
      irq_pend_q     <= 1'b0;
      irq_asserted_q <= 1'b0;
      ticks_q        <= '0;
      out_valid_q    <= 1'b0;
      skid_valid_q   <= 1'b0;
    end else begin
      chips_q        <= chips_d;
      bank_mask_q    <= bank_mask_d;
      addr_mask_q    <= addr_mask_d;
      status_q       <= status_d;
      command_q      <= command_d;
      host_q         <= host_d;
      host_sh_q      <= host_sh_d;
      exp_q          <= exp_d;
      exp_sh_q       <= exp_sh_d;
      bank_q         <= bank_d;
      bank_sh_q      <= bank_sh_d;
      len_q          <= len_d;
      len_sh_q       <= len_sh_d;
      irq_mask_q     <= irq_mask_d;
      ac_q           <= ac_d;
      wait_ff00_q    <= wait_ff00_d;
      irq_pend_q     <= irq_pend_d;
      irq_asserted_q <= irq_asserted_d;
      ticks_q        <= ticks_d;
      out_valid_q    <= out_valid_d;
      skid_valid_q   <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = out_q.read_data;
  assign start_transfer_o   = out_q.start_transfer;
  assign irq_drive_o        = out_q.irq_drive;
  assign cur_command_o      = out_q.cur_command;
  assign cur_host_addr_o    = out_q.cur_host_addr;
  assign cur_reu_addr_o     = out_q.cur_reu_addr;
  assign cur_length_o       = out_q.cur_length;
  assign cur_addr_control_o = out_q.cur_addr_control;

endmodule

// ----- sim/dma_expander_register_file_tb.sv -----
module dma_expander_register_file_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmaexp_pkg::*;

  localparam int unsigned HOLD_TICKS     = 1000;
  localparam int unsigned RX_HOLD_CYCLES = 80;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned END_CYCLES     = 8;
  localparam int unsigned PHASE_WORDS    = 230;
  localparam int unsigned DIR_ROWS       = 27;

  // one host bus cycle as offered to the block
  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  off;
    logic [7:0]  data;
    logic        rst;
    logic        line;
    logic [15:0] dh;
    logic [23:0] dr;
    logic [15:0] dl;
    logic        eob;
    logic        verr;
  } bus_word_t;

  // directed row: done fields are all ones or all zeros, rd is quoted when typed is set
  typedef struct packed {
    logic [2:0] op;
    logic [4:0] off;
    logic [7:0] data;
    logic       line;
    logic       ones;
    logic       eob;
    logic       verr;
    logic       typed;
    logic [7:0] rd;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  op_i;
  logic [4:0]  reg_offset_i;
  logic [7:0]  write_data_i;
  logic        cpu_reset_low_i;
  logic        irq_line_low_i;
  logic [15:0] done_host_addr_i;
  logic [23:0] done_reu_addr_i;
  logic [15:0] done_length_i;
  logic        done_end_of_block_i;
  logic        done_verify_error_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_data_o;
  logic        start_transfer_o;
  logic        irq_drive_o;
  logic [7:0]  cur_command_o;
  logic [15:0] cur_host_addr_o;
  logic [23:0] cur_reu_addr_o;
  logic [15:0] cur_length_o;
  logic [7:0]  cur_addr_control_o;

  dma_expander_register_file #(
    .RESET_HOLD_TICKS(HOLD_TICKS)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .op_i                (op_i),
    .reg_offset_i        (reg_offset_i),
    .write_data_i        (write_data_i),
    .cpu_reset_low_i     (cpu_reset_low_i),
    .irq_line_low_i      (irq_line_low_i),
    .done_host_addr_i    (done_host_addr_i),
    .done_reu_addr_i     (done_reu_addr_i),
    .done_length_i       (done_length_i),
    .done_end_of_block_i (done_end_of_block_i),
    .done_verify_error_i (done_verify_error_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .read_data_o         (read_data_o),
    .start_transfer_o    (start_transfer_o),
    .irq_drive_o         (irq_drive_o),
    .cur_command_o       (cur_command_o),
    .cur_host_addr_o     (cur_host_addr_o),
    .cur_reu_addr_o      (cur_reu_addr_o),
    .cur_length_o        (cur_length_o),
    .cur_addr_control_o  (cur_addr_control_o)
  );

  // predictor copy of the register file
  logic        chips_cfg;
  logic [7:0]  bank_mask_cfg;
  logic [23:0] addr_mask_cfg;
  logic [7:0]  p_status, p_command, p_bank, p_bank_sh, p_irq_mask, p_addr_ctrl;
  logic [15:0] p_host, p_host_sh, p_exp, p_exp_sh, p_len, p_len_sh;
  logic        p_ff00_armed, p_irq_pending, p_irq_driven;
  ticks_t      p_hold_ticks;

  res_t        snapshots[$];
  int          quoted_reads[$];
  int unsigned fails;
  int unsigned idle_cycles;
  logic        tx_calm, rx_calm, rx_hold_req;
  dir_row_t    dir_tab [DIR_ROWS];

  function automatic void clear_regs();
    p_irq_driven            = 1'b0;
    p_irq_pending           = 1'b0;
    p_ff00_armed            = 1'b0;
    p_status[ST_CHIPS]      = chips_cfg;
    p_command               = CMD_RESET;
    p_len                   = LEN_RESET;
    p_len_sh                = LEN_RESET;
    p_host                  = '0;
    p_exp                   = '0;
    p_exp_sh                = '0;
    p_bank                  = bank_mask_cfg;
    p_bank_sh               = bank_mask_cfg;
    p_irq_mask              = IM_UNUSED;
    p_addr_ctrl             = AC_UNUSED;
  endfunction

  function automatic void power_up();
    chips_cfg     = 1'b1;
    bank_mask_cfg = BANK_MASK_RST;
    addr_mask_cfg = ADDR_MASK_RST;
    p_status      = '0;
    p_host_sh     = '0;
    p_hold_ticks  = '0;
    clear_regs();
  endfunction

  function automatic void raise_irq(int unsigned cause, int unsigned enable_bit);
    if (p_status[cause] && p_irq_mask[enable_bit] && p_irq_mask[IM_ENABLE]) begin
      p_status[ST_IRQ] = 1'b1;
      p_irq_pending    = 1'b1;
    end
  endfunction

  // advance the register file by one bus cycle and return the register snapshot
  function automatic res_t bus_cycle(bus_word_t w);
    res_t        r;
    logic [7:0]  rd;
    logic        start;
    logic [23:0] ra;
    rd    = '0;
    start = 1'b0;
    if (w.rst) begin
      if (p_hold_ticks != TICKS_MAX) p_hold_ticks = p_hold_ticks + 1'b1;
      if (p_hold_ticks > HOLD_TICKS) clear_regs();
    end else begin
      p_hold_ticks = '0;
    end
    case (w.op)
      OP_WRITE: begin
        if (w.off == REG_COMMAND && w.data[CMD_EXEC] && w.data[CMD_NOFF]) begin
          p_command    = w.data;
          start        = 1'b1;
          p_ff00_armed = 1'b0;
        end else begin
          case (w.off)
            REG_COMMAND: begin
              p_command = w.data;
              if (w.data[CMD_EXEC]) p_ff00_armed = 1'b1;
            end
            REG_HOST_LO: begin
              p_host_sh[7:0] = w.data;
              p_host         = p_host_sh;
            end
            REG_HOST_HI: begin
              p_host_sh[15:8] = w.data;
              p_host          = p_host_sh;
            end
            REG_EXP_LO: begin
              p_exp_sh[7:0] = w.data;
              p_exp         = p_exp_sh;
            end
            REG_EXP_HI: begin
              p_exp_sh[15:8] = w.data;
              p_exp          = p_exp_sh;
            end
            REG_BANK: begin
              p_bank_sh = w.data & ~bank_mask_cfg;
              p_bank    = p_bank_sh;
            end
            REG_LEN_LO: begin
              p_len_sh[7:0] = w.data;
              p_len         = p_len_sh;
            end
            REG_LEN_HI: begin
              p_len_sh[15:8] = w.data;
              p_len          = p_len_sh;
            end
            REG_IRQ_MASK: begin
              p_irq_mask = w.data | IM_UNUSED;
              raise_irq(ST_EOB, IM_EOB);
              raise_irq(ST_VERR, IM_VERR);
            end
            REG_ADDR_CTRL: p_addr_ctrl = w.data | AC_UNUSED;
            default: ;
          endcase
        end
      end
      OP_READ: begin
        case (w.off)
          REG_STATUS: begin
            rd                = p_status;
            p_status[ST_IRQ]  = 1'b0;
            p_status[ST_EOB]  = 1'b0;
            p_status[ST_VERR] = 1'b0;
            p_irq_driven      = 1'b0;
          end
          REG_COMMAND:   rd = p_command;
          REG_HOST_LO:   rd = p_host[7:0];
          REG_HOST_HI:   rd = p_host[15:8];
          REG_EXP_LO:    rd = p_exp[7:0];
          REG_EXP_HI:    rd = p_exp[15:8];
          REG_BANK:      rd = p_bank | bank_mask_cfg;
          REG_LEN_LO:    rd = p_len[7:0];
          REG_LEN_HI:    rd = p_len[15:8];
          REG_IRQ_MASK:  rd = p_irq_mask;
          REG_ADDR_CTRL: rd = p_addr_ctrl;
          default:       rd = UNUSED_READ;
        endcase
      end
      OP_FF00: begin
        if (p_ff00_armed) begin
          start        = 1'b1;
          p_ff00_armed = 1'b0;
        end
      end
      OP_DONE: begin
        ra                = w.dr & addr_mask_cfg;
        p_status[ST_EOB]  = p_status[ST_EOB] | w.eob;
        p_status[ST_VERR] = p_status[ST_VERR] | w.verr;
        if (!p_command[CMD_AUTO]) begin
          if (!p_addr_ctrl[AC_FIXH]) p_host = w.dh;
          if (!p_addr_ctrl[AC_FIXR]) begin
            p_exp  = ra[15:0];
            p_bank = ra[23:16];
          end
          p_len = w.dl;
        end else begin
          // autoload: reload everything from the shadows
          p_host = p_host_sh;
          p_exp  = p_exp_sh;
          p_bank = p_bank_sh;
          p_len  = p_len_sh;
        end
        if (w.eob) raise_irq(ST_EOB, IM_EOB);
        if (w.verr) raise_irq(ST_VERR, IM_VERR);
      end
      default: ;
    endcase
    // pending request takes the line once nobody else holds it low
    if (p_irq_pending && !w.line) begin
      p_irq_pending = 1'b0;
      p_irq_driven  = 1'b1;
    end
    r.read_data        = rd;
    r.start_transfer   = start;
    r.irq_drive        = p_irq_driven;
    r.cur_command      = p_command;
    r.cur_host_addr    = p_host;
    r.cur_reu_addr     = {p_bank, p_exp};
    r.cur_length       = p_len;
    r.cur_addr_control = p_addr_ctrl;
    return r;
  endfunction

  task automatic check_snapshot(res_t want, res_t got);
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
      fails++;
    end
    if (got.start_transfer !== want.start_transfer) begin
      $error("start_transfer: expected %0h, got %0h", want.start_transfer, got.start_transfer);
      fails++;
    end
    if (got.irq_drive !== want.irq_drive) begin
      $error("irq_drive: expected %0h, got %0h", want.irq_drive, got.irq_drive);
      fails++;
    end
    if (got.cur_command !== want.cur_command) begin
      $error("cur_command: expected %0h, got %0h", want.cur_command, got.cur_command);
      fails++;
    end
    if (got.cur_host_addr !== want.cur_host_addr) begin
      $error("cur_host_addr: expected %0h, got %0h", want.cur_host_addr, got.cur_host_addr);
      fails++;
    end
    if (got.cur_reu_addr !== want.cur_reu_addr) begin
      $error("cur_reu_addr: expected %0h, got %0h", want.cur_reu_addr, got.cur_reu_addr);
      fails++;
    end
    if (got.cur_length !== want.cur_length) begin
      $error("cur_length: expected %0h, got %0h", want.cur_length, got.cur_length);
      fails++;
    end
    if (got.cur_addr_control !== want.cur_addr_control) begin
      $error("cur_addr_control: expected %0h, got %0h",
             want.cur_addr_control, got.cur_addr_control);
      fails++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : scoreboard
    res_t      want;
    res_t      got;
    bus_word_t w;
    int        quoted;
    if (rst_ni) begin
      idle_cycles++;
      if (out_valid_o && !out_stall_i) begin
        idle_cycles = 0;
        got = {read_data_o, start_transfer_o, irq_drive_o, cur_command_o,
               cur_host_addr_o, cur_reu_addr_o, cur_length_o, cur_addr_control_o};
        if (snapshots.size() == 0) begin
          $error("result word arrived with nothing outstanding");
          fails++;
        end else begin
          check_snapshot(snapshots.pop_front(), got);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        idle_cycles = 0;
        w = {op_i, reg_offset_i, write_data_i, cpu_reset_low_i, irq_line_low_i,
             done_host_addr_i, done_reu_addr_i, done_length_i,
             done_end_of_block_i, done_verify_error_i};
        want = bus_cycle(w);
        if (quoted_reads.size() != 0) begin
          quoted = quoted_reads.pop_front();
          if (quoted >= 0) want.read_data = quoted[7:0];
        end
        snapshots.push_back(want);
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (idle_cycles < WATCHDOG_LIMIT);
    $display("dma_expander_register_file: mismatch");
    $finish;
  end

  function automatic int unsigned pause_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // result side: random stalls plus one long hold-off on request
  initial begin : rx_side
    int unsigned left;
    left        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall_i = 1'b1;
        left        = RX_HOLD_CYCLES - 1;
      end else if (left != 0) begin
        out_stall_i = 1'b1;
        left--;
      end else begin
        left = (!rx_calm && $urandom_range(0, 2) == 0) ? pause_len() : 0;
        out_stall_i = (left != 0);
        if (left != 0) left--;
      end
    end
  end

  // offer one word, hold it until taken, then maybe idle
  task automatic put_word(bus_word_t w);
    int unsigned gap;
    {op_i, reg_offset_i, write_data_i, cpu_reset_low_i, irq_line_low_i,
     done_host_addr_i, done_reu_addr_i, done_length_i,
     done_end_of_block_i, done_verify_error_i} = w;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    gap = tx_calm ? 0 : pause_len();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (snapshots.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_config(logic [1:0] idx, logic [23:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_CHIPS:     chips_cfg     = val[0];
      CFG_BANK_MASK: bank_mask_cfg = val[7:0];
      CFG_ADDR_MASK: addr_mask_cfg = val;
      default: ;
    endcase
  endtask

  task automatic retune(logic chips, logic [7:0] bank_mask, logic [23:0] addr_mask);
    drain();
    repeat (2) @(negedge clk_i);
    set_config(CFG_CHIPS, {23'd0, chips});
    set_config(CFG_BANK_MASK, {16'd0, bank_mask});
    set_config(CFG_ADDR_MASK, addr_mask);
  endtask

  function automatic bus_word_t rand_word(logic rst);
    bus_word_t   w;
    logic [95:0] bits;
    int unsigned pick;
    bits = {$urandom, $urandom, $urandom};
    w    = bits[75:0];
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w.op  = OP_WRITE;
      w.off = 5'($urandom_range(REG_COMMAND, REG_ADDR_CTRL));
      if (w.off == REG_COMMAND && $urandom_range(0, 1) == 1) w.data[CMD_EXEC] = 1'b1;
    end else if (pick < 60) begin
      w.op = OP_READ;
      if ($urandom_range(0, 9) == 0) w.off = 5'($urandom_range(0, 31));
      else if ($urandom_range(0, 2) == 0) w.off = REG_STATUS;
      else w.off = 5'($urandom_range(REG_STATUS, REG_ADDR_CTRL));
    end else if (pick < 75) begin
      w.op = OP_DONE;
    end else if (pick < 85) begin
      w.op = OP_FF00;
    end else if (pick < 93) begin
      w.op = OP_TICK;
    end else begin
      // noise: unused opcodes and unused offsets
      w.op = 3'($urandom_range(0, 7));
    end
    w.rst  = rst;
    w.line = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  task automatic run_traffic(int unsigned n, int unsigned hold_len);
    int unsigned burst;
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 128 == 0) begin
        tx_calm = ($urandom_range(0, 4) == 0);
        rx_calm = ($urandom_range(0, 4) == 0);
      end
      if (i == n / 4) begin
        tx_calm     = 1'b1;
        rx_hold_req = 1'b1;
      end
      // long host reset: crosses the hold threshold when hold_len exceeds it
      if (i == n / 2)
        for (int unsigned k = 0; k < hold_len; k++) put_word(rand_word(1'b1));
      if (i == 3 * n / 4) drain();
      if (burst == 0 && $urandom_range(0, 49) == 0) burst = $urandom_range(1, 6);
      put_word(rand_word(burst != 0));
      if (burst != 0) burst--;
    end
  endtask

  initial begin : stimulus
    bus_word_t w;
    dir_row_t  row;
    fails               = 0;
    idle_cycles         = 0;
    tx_calm             = 1'b0;
    rx_calm             = 1'b0;
    rx_hold_req         = 1'b0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = '0;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    op_i                = OP_TICK;
    reg_offset_i        = '0;
    write_data_i        = '0;
    cpu_reset_low_i     = 1'b0;
    irq_line_low_i      = 1'b0;
    done_host_addr_i    = '0;
    done_reu_addr_i     = '0;
    done_length_i       = '0;
    done_end_of_block_i = 1'b0;
    done_verify_error_i = 1'b0;
    power_up();

    dir_tab = '{
      '{OP_READ,  REG_STATUS,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h10},
      '{OP_READ,  REG_COMMAND,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h10},
      '{OP_READ,  REG_BANK,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hf8},
      '{OP_READ,  REG_LEN_HI,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff},
      '{OP_READ,  REG_IRQ_MASK,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h1f},
      '{OP_READ,  REG_ADDR_CTRL, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h3f},
      '{OP_READ,  5'd31,         8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff},
      '{OP_WRITE, REG_STATUS,    8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, 5'd11,         8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, REG_HOST_LO,   8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, REG_HOST_HI,   8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, REG_EXP_HI,    8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, REG_BANK,      8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_READ,  REG_BANK,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hff},
      '{OP_WRITE, REG_LEN_LO,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, REG_IRQ_MASK,  8'he0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, REG_ADDR_CTRL, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, REG_COMMAND,   8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_FF00,  REG_STATUS,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_FF00,  REG_STATUS,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_WRITE, REG_COMMAND,   8'h90, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_DONE,  REG_STATUS,    8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00},
      '{OP_TICK,  REG_STATUS,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_READ,  REG_STATUS,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'hf0},
      '{OP_READ,  REG_STATUS,    8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h10},
      '{OP_WRITE, REG_COMMAND,   8'h20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
      '{OP_DONE,  REG_STATUS,    8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}
    };

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    retune(1'b1, BANK_MASK_RST, ADDR_MASK_RST);
    for (int unsigned i = 0; i < DIR_ROWS; i++) begin
      row    = dir_tab[i];
      w.op   = row.op;
      w.off  = row.off;
      w.data = row.data;
      w.rst  = 1'b0;
      w.line = row.line;
      w.dh   = {16{row.ones}};
      w.dr   = {24{row.ones}};
      w.dl   = {16{row.ones}};
      w.eob  = row.eob;
      w.verr = row.verr;
      quoted_reads.push_back(row.typed ? int'(row.rd) : -1);
      put_word(w);
    end
    run_traffic(PHASE_WORDS, $urandom_range(HOLD_TICKS + 1, HOLD_TICKS + 4));

    retune(1'b0, 8'h00, 24'hffffff);
    run_traffic(PHASE_WORDS, 0);

    retune(1'b1, 8'hff, 24'h000000);
    run_traffic(PHASE_WORDS, 0);

    retune(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 24'($urandom));
    run_traffic(PHASE_WORDS, 0);

    drain();
    repeat (END_CYCLES) @(negedge clk_i);
    if (fails == 0)
      $display("dma_expander_register_file: match");
    else
      $display("dma_expander_register_file: mismatch");
    $finish;
  end

endmodule
